@@ src/dvfs_pkg.sv @@
// shared types and constants of the dvfs domain controller
package dvfs_pkg;

   localparam int unsigned FREQ_W    = 16;
   localparam int unsigned TICK_W    = 16;
   localparam int unsigned COUNT_W   = 3;
   localparam int unsigned TABLE_W   = 64;
   localparam int unsigned SLOT_W    = 16;
   localparam int unsigned CSR_ADDR_W = 6;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [FREQ_W-1:0] FREQ_MIN_RST = 16'd200;
   localparam logic [FREQ_W-1:0] FREQ_MAX_RST = 16'd2000;

   typedef enum logic [1:0] {
      CMD_REQUEST = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_QUERY   = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_APPLIED = 3'd0,
      ST_STARTED = 3'd1,
      ST_LOCKED  = 3'd2,
      ST_BUSY    = 3'd3,
      ST_RANGE   = 3'd4,
      ST_DONE    = 3'd5,
      ST_NOTHING = 3'd6,
      ST_ANSWER  = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      REG_FREQ_MIN   = 3'd0,
      REG_FREQ_MAX   = 3'd1,
      REG_TICKS      = 3'd2,
      REG_LOCKED     = 3'd3,
      REG_MODE_COUNT = 3'd4,
      REG_MODE_TABLE = 3'd5,
      REG_SPARE6     = 3'd6,
      REG_SPARE7     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [FREQ_W-1:0]  freq_min_mhz;
      logic [FREQ_W-1:0]  freq_max_mhz;
      logic [TICK_W-1:0]  transition_ticks;
      logic               locked;
      logic [COUNT_W-1:0] mode_count;
      logic [TABLE_W-1:0] mode_table;
   } cfg_type;

   typedef struct packed {
      status_type        status;
      logic [FREQ_W-1:0] current_mhz;
      logic [FREQ_W-1:0] answer_mhz;
      logic              in_transition;
      logic [FREQ_W-1:0] previous_mhz;
      logic              begin_pulse;
      logic              end_pulse;
      logic              changed_pulse;
   } rsp_type;

endpackage

@@ src/dvfs_csr.sv @@
// configuration register file with apb-style access
module dvfs_csr import dvfs_pkg::*; #(
   parameter int unsigned FREQ_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [FREQ_BITS-1:0] freq_min_ff, freq_min_in;
   logic [FREQ_BITS-1:0] freq_max_ff, freq_max_in;
   logic [TICK_W-1:0]    ticks_ff, ticks_in;
   logic                 locked_ff, locked_in;
   logic [COUNT_W-1:0]   mode_count_ff, mode_count_in;
   logic [TABLE_W-1:0]   mode_table_ff, mode_table_in;
   logic                 wr_en;
   reg_index_type        index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = reg_index_type'(csr_paddr[5:3]);

   always_comb begin
      freq_min_in   = freq_min_ff;
      freq_max_in   = freq_max_ff;
      ticks_in      = ticks_ff;
      locked_in     = locked_ff;
      mode_count_in = mode_count_ff;
      mode_table_in = mode_table_ff;
      if (wr_en) begin
         case (index)
            REG_FREQ_MIN:   freq_min_in   = csr_pwdata[FREQ_BITS-1:0];
            REG_FREQ_MAX:   freq_max_in   = csr_pwdata[FREQ_BITS-1:0];
            REG_TICKS:      ticks_in      = csr_pwdata[TICK_W-1:0];
            REG_LOCKED:     locked_in     = csr_pwdata[0];
            REG_MODE_COUNT: mode_count_in = csr_pwdata[COUNT_W-1:0];
            REG_MODE_TABLE: mode_table_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_min_ff   <= FREQ_BITS'(FREQ_MIN_RST);
         freq_max_ff   <= FREQ_BITS'(FREQ_MAX_RST);
         ticks_ff      <= '0;
         locked_ff     <= 1'b0;
         mode_count_ff <= '0;
         mode_table_ff <= '0;
      end else begin
         freq_min_ff   <= freq_min_in;
         freq_max_ff   <= freq_max_in;
         ticks_ff      <= ticks_in;
         locked_ff     <= locked_in;
         mode_count_ff <= mode_count_in;
         mode_table_ff <= mode_table_in;
      end
   end

   always_comb begin
      case (index)
         REG_FREQ_MIN:   csr_prdata = CSR_DATA_W'(freq_min_ff);
         REG_FREQ_MAX:   csr_prdata = CSR_DATA_W'(freq_max_ff);
         REG_TICKS:      csr_prdata = CSR_DATA_W'(ticks_ff);
         REG_LOCKED:     csr_prdata = CSR_DATA_W'(locked_ff);
         REG_MODE_COUNT: csr_prdata = CSR_DATA_W'(mode_count_ff);
         REG_MODE_TABLE: csr_prdata = mode_table_ff;
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.freq_min_mhz     = FREQ_W'(freq_min_ff);
   assign cfg.freq_max_mhz     = FREQ_W'(freq_max_ff);
   assign cfg.transition_ticks = ticks_ff;
   assign cfg.locked           = locked_ff;
   assign cfg.mode_count       = mode_count_ff;
   assign cfg.mode_table       = mode_table_ff;

endmodule

@@ src/dvfs_engine.sv @@
// domain state and per-word decision logic
module dvfs_engine import dvfs_pkg::*; #(
   parameter int unsigned NUM_MODES = 4,
   parameter int unsigned FREQ_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  cmd_type              cmd,
   input  logic [FREQ_BITS-1:0] freq,
   input  cfg_type              cfg,
   output rsp_type              rsp
);

   logic [FREQ_BITS-1:0] active_ff, active_in;
   logic [FREQ_BITS-1:0] pending_ff, pending_in;
   logic                 busy_ff, busy_in;
   logic [TICK_W-1:0]    ticks_ff, ticks_in, ticks_dec;

   logic [FREQ_BITS-1:0] mode [NUM_MODES];
   logic [COUNT_W-1:0]   n_used;
   logic [FREQ_BITS-1:0] fmin, fmax, range_lo, range_hi, ceil_val;
   logic [FREQ_BITS-1:0] prev, answer;
   status_type           status;
   logic                 begin_p, end_p, changed_p;

   for (genvar i = 0; i < NUM_MODES; i++) begin : g_mode
      assign mode[i] = cfg.mode_table[SLOT_W*i +: FREQ_BITS];
   end

   assign fmin   = cfg.freq_min_mhz[FREQ_BITS-1:0];
   assign fmax   = cfg.freq_max_mhz[FREQ_BITS-1:0];
   assign n_used = (cfg.mode_count > COUNT_W'(NUM_MODES)) ? COUNT_W'(NUM_MODES)
                                                          : cfg.mode_count;

   // range bounds and ceil-to-mode, or clamp to min and max when no modes are set
   always_comb begin
      range_hi = fmax;
      ceil_val = '0;
      for (int i = 0; i < NUM_MODES; i++) begin
         if (COUNT_W'(i + 1) == n_used) begin
            range_hi = mode[i];
            ceil_val = mode[i];
         end
      end
      for (int i = NUM_MODES - 1; i >= 0; i--) begin
         if (COUNT_W'(i) < n_used && mode[i] >= freq) begin
            ceil_val = mode[i];
         end
      end
      range_lo = (n_used != '0) ? mode[0] : fmin;
      if (n_used == '0) begin
         if (freq < fmin) begin
            ceil_val = fmin;
         end else if (freq > fmax) begin
            ceil_val = fmax;
         end else begin
            ceil_val = freq;
         end
      end
   end

   assign ticks_dec = (ticks_ff != '0) ? ticks_ff - 1'b1 : ticks_ff;

   always_comb begin
      active_in  = active_ff;
      pending_in = pending_ff;
      busy_in    = busy_ff;
      ticks_in   = ticks_ff;
      status     = ST_NOTHING;
      answer     = '0;
      prev       = '0;
      begin_p    = 1'b0;
      end_p      = 1'b0;
      changed_p  = 1'b0;
      case (cmd)
         CMD_REQUEST: begin
            if (cfg.locked) begin
               status = ST_LOCKED;
            end else if (busy_ff) begin
               status = ST_BUSY;
            end else if (freq < range_lo || freq > range_hi) begin
               status = ST_RANGE;
            end else if (cfg.transition_ticks == '0) begin
               prev      = active_ff;
               active_in = freq;
               status    = ST_APPLIED;
               changed_p = 1'b1;
            end else begin
               busy_in    = 1'b1;
               pending_in = freq;
               ticks_in   = cfg.transition_ticks;
               status     = ST_STARTED;
               begin_p    = 1'b1;
            end
         end
         CMD_TICK: begin
            if (busy_ff) begin
               ticks_in = ticks_dec;
               if (ticks_dec == '0) begin
                  prev      = active_ff;
                  active_in = pending_ff;
                  busy_in   = 1'b0;
                  status    = ST_DONE;
                  end_p     = 1'b1;
                  changed_p = 1'b1;
               end
            end
         end
         CMD_QUERY: begin
            answer = ceil_val;
            status = ST_ANSWER;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= FREQ_BITS'(FREQ_MAX_RST);
         pending_ff <= '0;
         busy_ff    <= 1'b0;
         ticks_ff   <= '0;
      end else if (fire) begin
         active_ff  <= active_in;
         pending_ff <= pending_in;
         busy_ff    <= busy_in;
         ticks_ff   <= ticks_in;
      end
   end

   assign rsp.status        = status;
   assign rsp.current_mhz   = FREQ_W'(active_in);
   assign rsp.answer_mhz    = FREQ_W'(answer);
   assign rsp.in_transition = busy_in;
   assign rsp.previous_mhz  = FREQ_W'(prev);
   assign rsp.begin_pulse   = begin_p;
   assign rsp.end_pulse     = end_p;
   assign rsp.changed_pulse = changed_p;

endmodule

@@ src/dvfs_domain_controller.sv @@
// top level of the dvfs domain controller
//
// Frequency controller for one clock domain. Words enter on the req_ stream:
// req_tuser carries the command (request, tick, ceil query) and req_tdata the
// frequency in MHz. Every word gives exactly one rsp_ word with the status in
// rsp_tuser and the frequencies and pulses in rsp_tdata.
// An accepted word is held in the input register while the decision against
// the domain state and the mode table is made in one pass, and the result
// lands in the output register, which drives rsp_tvalid.
// Throughput is one word per cycle; req_tready stays high while the input
// register is empty, or the output one is empty or taken in the same cycle.
// When rsp_tready is low the output word holds, the input register fills, and
// then req_tready drops until the receiver takes the result.
// Reset (synchronous) empties both registers, loads the register reset
// values (min 200, max 2000, no delay, unlocked, no modes) and sets the
// frequency in effect to 2000 MHz with no transition pending.
// Registers sit on the csr_ port at 8-byte steps; the user must write them
// only while no word is in flight, as the block itself does not enforce it.
module dvfs_domain_controller import dvfs_pkg::*; #(
   parameter int unsigned NUM_MODES = 4,
   parameter int unsigned FREQ_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // freq_mhz[15:0]
   input  logic [1:0]            req_tuser,   // cmd[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // current_mhz[15:0] answer_mhz[31:16] in_transition[32] previous_mhz[48:33]
   // begin_pulse[49] end_pulse[50] changed_pulse[51] zero[55:52]
   output logic [55:0]           rsp_tdata,
   output logic [2:0]            rsp_tuser,   // status[2:0]
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type              cfg;
   rsp_type              rsp_next;
   rsp_type              out_ff;
   logic                 out_valid_ff;
   logic                 in_valid_ff;
   cmd_type              in_cmd_ff;
   logic [FREQ_BITS-1:0] in_freq_ff;
   logic                 advance;
   logic                 req_take;

   dvfs_csr #(
      .FREQ_BITS (FREQ_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dvfs_engine #(
      .NUM_MODES (NUM_MODES),
      .FREQ_BITS (FREQ_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .cmd   (in_cmd_ff),
      .freq  (in_freq_ff),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= cmd_type'(req_tuser);
         in_freq_ff <= req_tdata[FREQ_BITS-1:0];
      end
      if (advance) begin
         out_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {4'b0000,
                        out_ff.changed_pulse,
                        out_ff.end_pulse,
                        out_ff.begin_pulse,
                        out_ff.previous_mhz,
                        out_ff.in_transition,
                        out_ff.answer_mhz,
                        out_ff.current_mhz};

endmodule
